// ===== src/lptf_pkg.sv =====
// types, codes and constants for the length-prefixed token frame parser
// no dependencies; imported by every module of the block
package lptf_pkg;

    localparam int FIELD_BYTES = 4;
    localparam int FCNT_W      = $clog2(FIELD_BYTES);
    localparam logic [15:0] MAX_TOKENS_RESET = 16'd1024;

    typedef enum logic [1:0] {
        PH_COUNT   = 2'd0,
        PH_LENGTH  = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_DONE    = 2'd3
    } phase_t;

    localparam logic [1:0] ROLE_COUNT   = 2'd0;
    localparam logic [1:0] ROLE_LENGTH  = 2'd1;
    localparam logic [1:0] ROLE_PAYLOAD = 2'd2;
    localparam logic [1:0] ROLE_IGNORED = 2'd3;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_TOO_MANY = 2'd1;
    localparam logic [1:0] ERR_TRUNC    = 2'd2;
    localparam logic [1:0] ERR_TRAIL    = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_last;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]  byte_role;
        logic [15:0] token_index;
        logic [7:0]  payload_byte;
        logic [31:0] token_length;
        logic        token_last;
        logic        frame_done;
        logic        frame_ok;
        logic [1:0]  error_kind;
    } out_beat_t;

    typedef struct packed {
        phase_t            phase;
        logic [FCNT_W-1:0] field_byte_count;
        logic [31:0]       field_accumulator;
        logic [31:0]       tokens_expected;
        logic [31:0]       tokens_done;
        logic [31:0]       payload_left;
        logic [1:0]        error_seen;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        phase:             PH_COUNT,
        field_byte_count:  '0,
        field_accumulator: '0,
        tokens_expected:   '0,
        tokens_done:       '0,
        payload_left:      '0,
        error_seen:        ERR_NONE
    };

endpackage

// ===== src/lptf_step.sv =====
// per-beat parse logic: next frame state and result beat for one input byte
// depends on lptf_pkg
module lptf_step
    import lptf_pkg::*;
(
    input  parse_state_t st,
    input  in_beat_t     beat,
    input  logic [15:0]  max_tokens,
    output parse_state_t st_next,
    output out_beat_t    res
);

    logic        field_full;
    logic [31:0] field_value;
    logic [31:0] acc_lane;
    logic [31:0] done_inc;
    logic [31:0] left_dec;
    phase_t      finish_phase;

    assign field_full  = (st.field_byte_count == FCNT_W'(FIELD_BYTES - 1));
    assign field_value = {beat.data_byte, st.field_accumulator[23:0]};
    assign done_inc    = st.tokens_done + 32'd1;
    assign left_dec    = st.payload_left - 32'd1;
    assign finish_phase = (done_inc >= st.tokens_expected) ? PH_DONE : PH_LENGTH;

    always_comb begin
        acc_lane = st.field_accumulator;
        acc_lane[8*st.field_byte_count +: 8] = beat.data_byte;
    end

    always_comb begin
        st_next = st;
        res     = '0;
        res.byte_role  = ROLE_IGNORED;
        res.frame_done = beat.frame_last;

        if (st.error_seen != ERR_NONE) begin
            res.byte_role = ROLE_IGNORED;
        end else begin
            case (st.phase)
                PH_COUNT: begin
                    res.byte_role = ROLE_COUNT;
                    if (field_full) begin
                        st_next.field_byte_count  = '0;
                        st_next.field_accumulator = '0;
                        st_next.tokens_expected   = field_value;
                        if (field_value > {16'd0, max_tokens}) begin
                            st_next.error_seen = ERR_TOO_MANY;
                        end else if (field_value == 32'd0) begin
                            st_next.phase = PH_DONE;
                        end else begin
                            st_next.phase = PH_LENGTH;
                        end
                    end else begin
                        st_next.field_byte_count  = st.field_byte_count + FCNT_W'(1);
                        st_next.field_accumulator = acc_lane;
                    end
                end
                PH_LENGTH: begin
                    res.byte_role   = ROLE_LENGTH;
                    res.token_index = st.tokens_done[15:0];
                    if (field_full) begin
                        st_next.field_byte_count  = '0;
                        st_next.field_accumulator = '0;
                        res.token_length          = field_value;
                        if (field_value == 32'd0) begin
                            res.token_last      = 1'b1;
                            st_next.tokens_done = done_inc;
                            st_next.phase       = finish_phase;
                        end else begin
                            st_next.payload_left = field_value;
                            st_next.phase        = PH_PAYLOAD;
                        end
                    end else begin
                        st_next.field_byte_count  = st.field_byte_count + FCNT_W'(1);
                        st_next.field_accumulator = acc_lane;
                    end
                end
                PH_PAYLOAD: begin
                    res.byte_role        = ROLE_PAYLOAD;
                    res.token_index      = st.tokens_done[15:0];
                    res.payload_byte     = beat.data_byte;
                    st_next.payload_left = left_dec;
                    if (left_dec == 32'd0) begin
                        res.token_last      = 1'b1;
                        st_next.tokens_done = done_inc;
                        st_next.phase       = finish_phase;
                    end
                end
                default: begin
                    res.byte_role      = ROLE_IGNORED;
                    st_next.error_seen = ERR_TRAIL;
                end
            endcase
        end

        // verdict on the frame's last beat, then back to the start state
        if (beat.frame_last) begin
            if (st_next.error_seen != ERR_NONE) begin
                res.error_kind = st_next.error_seen;
            end else if (st_next.phase == PH_DONE) begin
                res.frame_ok = 1'b1;
            end else begin
                res.error_kind = ERR_TRUNC;
            end
            st_next = STATE_RESET;
        end
    end

endmodule

// ===== src/length_prefixed_token_frame_parser.sv =====
// top level of the length-prefixed token frame parser: beat registers,
// frame state, max_tokens register; depends on lptf_pkg and lptf_step
//
// Usage:
//   s_valid/s_ready/s_data take the request frame one byte per beat, with
//   frame_last set on the final byte. Every input beat yields exactly one
//   result beat on m_valid/m_ready/m_data: the byte's role, its token index,
//   payload byte, decoded token length, token end mark and, on the last
//   byte, the frame verdict (frame_ok or error_kind).
//   cfg_valid/cfg_ready/cfg_data write max_tokens (reset value 1024); write
//   it only between frames while no beat is in flight. cfg_ready is always 1.
//   Throughput: one byte per clock unless m_ready stalls the result. A byte
//   passes from the input register through the parse logic to the result
//   register; the state update of one byte is combinational 32-bit add and
//   compare logic, so bytes can follow back to back.
//   Reset (aresetn low, synchronous) empties both beat registers, returns the
//   frame state to the count phase and restores max_tokens.
//   When m_ready is low a full result register holds; an empty input
//   register takes one more byte, then s_ready drops until the result drains.
module length_prefixed_token_frame_parser
    import lptf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_beat_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_beat_t   m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic         in_valid_reg,   in_valid_next;
    in_beat_t     in_beat_reg,    in_beat_next;
    logic         out_valid_reg,  out_valid_next;
    out_beat_t    out_beat_reg,   out_beat_next;
    parse_state_t state_reg,      state_next;
    logic [15:0]  max_tokens_reg, max_tokens_next;

    parse_state_t step_state;
    out_beat_t    step_res;
    logic         advance;

    lptf_step u_step (
        .st         (state_reg),
        .beat       (in_beat_reg),
        .max_tokens (max_tokens_reg),
        .st_next    (step_state),
        .res        (step_res)
    );

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_beat_reg;
    assign cfg_ready = 1'b1;

    always_comb begin
        in_valid_next   = in_valid_reg;
        in_beat_next    = in_beat_reg;
        out_valid_next  = out_valid_reg;
        out_beat_next   = out_beat_reg;
        state_next      = state_reg;
        max_tokens_next = max_tokens_reg;

        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
            in_beat_next  = s_data;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        if (advance) begin
            out_valid_next = 1'b1;
            out_beat_next  = step_res;
            state_next     = step_state;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid && cfg_ready) begin
            max_tokens_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            state_reg      <= STATE_RESET;
            max_tokens_reg <= MAX_TOKENS_RESET;
        end else begin
            in_valid_reg   <= in_valid_next;
            out_valid_reg  <= out_valid_next;
            state_reg      <= state_next;
            max_tokens_reg <= max_tokens_next;
        end
    end

    // beat payloads
    always_ff @(posedge aclk) begin
        in_beat_reg  <= in_beat_next;
        out_beat_reg <= out_beat_next;
    end

endmodule
